@@ rtl/page_frame_allocator_refcount_macros.svh @@
// Assertion macros for the page frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_MACROS_SVH

// Check cons in the same cycle as ante.
`define PFA_ASSERT_IMP(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PFA_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pfa_pkg.sv @@
package pfa_pkg;

    localparam int PAGES      = 32768;
    localparam int IDX_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 32;
    localparam int PN_W       = 20;
    localparam int CNT_W      = 8;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [PN_W-1:0] BASE_RESET = PN_W'(524288);
    localparam logic [PN_W-1:0] END_RESET  = PN_W'(557056);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_REF   = 2'd2,
        OP_DEREF = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ADDR  = 2'd1,
        ST_NO_MEM    = 2'd2,
        ST_COUNT_ERR = 2'd3
    } status_t;

    typedef enum logic {
        CFG_BASE = 1'b0,
        CFG_END  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic             bad;
        logic [IDX_W-1:0] idx;
    } item_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } link_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

@@ rtl/pfa_front.sv @@
module pfa_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [pfa_pkg::ADDR_W-1:0]    page_addr,
    input  logic [pfa_pkg::PN_W-1:0]      base_page,
    input  logic [pfa_pkg::PN_W-1:0]      end_page,
    input  logic                          clearing,
    input  pfa_pkg::q_stat_t              q_stat,
    output logic                          push,
    output pfa_pkg::item_t                item
);
    import pfa_pkg::*;

    logic [PN_W-1:0] pn;
    logic [PN_W-1:0] off;
    logic            in_range;
    logic            misaligned;
    op_t             op_dec;

    always_comb
    begin
        op_dec     = op_t'(op);
        pn         = page_addr[ADDR_W-1:PAGE_SHIFT];
        off        = pn - base_page;
        in_range   = (pn >= base_page) && (pn < end_page)
                     && ({1'b0, off} < (PN_W + 1)'(PAGES));
        misaligned = (page_addr[PAGE_SHIFT-1:0] != '0);
        item.op    = op_dec;
        item.idx   = off[IDX_W-1:0];
        case (op_dec)
            OP_ALLOC:         item.bad = 1'b0;
            OP_FREE:          item.bad = !in_range || misaligned;
            OP_REF, OP_DEREF: item.bad = !in_range;
            default:          item.bad = 1'b1;
        endcase
    end

    assign in_stall = clearing | q_stat.full;
    assign push     = in_valid & ~in_stall;

endmodule

@@ rtl/pfa_queue.sv @@
module pfa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pfa_pkg::item_t   push_item,
    input  logic             pop,
    output pfa_pkg::item_t   pop_item,
    output pfa_pkg::q_stat_t q_stat
);
    import pfa_pkg::*;

    item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = slot_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));

endmodule

@@ rtl/pfa_back.sv @@
module pfa_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pfa_pkg::PN_W-1:0]   base_page,
    input  pfa_pkg::q_stat_t           q_stat,
    input  pfa_pkg::item_t             pop_item,
    output logic                       pop,
    output logic                       clearing,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [pfa_pkg::ADDR_W-1:0] out_addr,
    output pfa_pkg::status_t           status,
    output logic                       page_released,
    output logic [pfa_pkg::CNT_W-1:0]  count_after
);
    import pfa_pkg::*;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    link_t            head_reg, head_next;
    logic             out_valid_reg, out_valid_next;

    item_t            cur_reg;
    logic [CNT_W-1:0] refs_rd_reg;
    link_t            next_rd_reg;

    logic [CNT_W-1:0] refs_mem [PAGES];
    link_t            next_mem [PAGES];

    logic             refs_we;
    logic [IDX_W-1:0] refs_waddr;
    logic [CNT_W-1:0] refs_wdata;
    logic             next_we;
    logic [IDX_W-1:0] next_waddr;
    link_t            next_wdata;

    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    status_t           status_reg, status_next;
    logic              rel_reg, rel_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [PN_W-1:0]   alloc_pn;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;
    logic              push_frame;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(PAGES - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (pop)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop          = (state_reg == BK_IDLE) && !q_stat.empty
                       && (!out_valid_reg || !out_stall);
        clearing     = (state_reg == BK_CLEAR);
        clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        head_next    = head_reg;

        alloc_pn = base_page + PN_W'(head_reg.idx);
        cnt_inc  = refs_rd_reg + 1'b1;
        cnt_dec  = refs_rd_reg - 1'b1;

        refs_we    = 1'b0;
        refs_waddr = cur_reg.idx;
        refs_wdata = '0;
        next_we    = 1'b0;
        next_waddr = cur_reg.idx;
        next_wdata = head_reg;
        push_frame = 1'b0;

        out_addr_next = '0;
        status_next   = ST_OK;
        rel_next      = 1'b0;
        cnt_next      = '0;

        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            BK_CLEAR:
            begin
                refs_we    = 1'b1;
                refs_waddr = clr_cnt_reg;
            end
            BK_EXEC:
            begin
                out_valid_next = 1'b1;
                if (cur_reg.op == OP_ALLOC)
                begin
                    if (!head_reg.valid)
                    begin
                        status_next = ST_NO_MEM;
                    end
                    else
                    begin
                        head_next     = next_rd_reg;
                        refs_we       = 1'b1;
                        refs_waddr    = head_reg.idx;
                        refs_wdata    = CNT_W'(1);
                        cnt_next      = CNT_W'(1);
                        out_addr_next = ADDR_W'({alloc_pn, {PAGE_SHIFT{1'b0}}});
                    end
                end
                else if (cur_reg.bad)
                begin
                    status_next = ST_BAD_ADDR;
                end
                else
                begin
                    case (cur_reg.op)
                        OP_FREE: push_frame = 1'b1;
                        OP_REF:
                        begin
                            if (refs_rd_reg == '1)
                            begin
                                status_next = ST_COUNT_ERR;
                                cnt_next    = refs_rd_reg;
                            end
                            else
                            begin
                                refs_we    = 1'b1;
                                refs_wdata = cnt_inc;
                                cnt_next   = cnt_inc;
                            end
                        end
                        OP_DEREF:
                        begin
                            if (refs_rd_reg == '0)
                            begin
                                status_next = ST_COUNT_ERR;
                            end
                            else
                            begin
                                refs_we    = 1'b1;
                                refs_wdata = cnt_dec;
                                cnt_next   = cnt_dec;
                                push_frame = (cnt_dec == '0);
                            end
                        end
                        default: status_next = ST_BAD_ADDR;
                    endcase
                    if (push_frame)
                    begin
                        next_we        = 1'b1;
                        head_next.valid = 1'b1;
                        head_next.idx  = cur_reg.idx;
                        refs_we        = 1'b1;
                        refs_wdata     = '0;
                        rel_next       = 1'b1;
                    end
                end
            end
            default:
            begin
                refs_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_item;
        end
        if (state_reg == BK_EXEC)
        begin
            out_addr_reg <= out_addr_next;
            status_reg   <= status_next;
            rel_reg      <= rel_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (refs_we)
        begin
            refs_mem[refs_waddr] <= refs_wdata;
        end
        if (pop)
        begin
            refs_rd_reg <= refs_mem[pop_item.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (pop)
        begin
            next_rd_reg <= next_mem[head_reg.idx];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_addr      = out_addr_reg;
    assign status        = status_reg;
    assign page_released = rel_reg;
    assign count_after   = cnt_reg;

endmodule

@@ rtl/page_frame_allocator_refcount.sv @@
// Page frame allocator with per-frame reference counts.
// Input channel: in_valid/in_stall carry op and page_addr; an item is taken
// at an edge where in_valid is high and in_stall is low. Ops: alloc pops the
// free list head, free pushes a frame, ref and deref adjust its count.
// Output channel: out_valid/out_stall carry one result per item: out_addr,
// status, page_released and count_after.
// Configuration: cfg_we writes cfg_data to region_base_page (index 0) or
// region_end_page (index 1); write only while no item is in flight.
// An item moves from the queue to the execution unit, which registers its
// result onto out_valid. The unit pops a new item only after the last, as
// the count and next-link memories are read before the update is written.
// A two-entry queue sits between the decode stage and the execution unit.
// Reset: the free list is empty and a clearing pass zeroes all 32768
// reference counts, one per cycle; in_stall stays high throughout the pass.
// When out_stall is high the result holds, the queue absorbs up to
// two further items, then in_stall rises.
`include "page_frame_allocator_refcount_macros.svh"

module page_frame_allocator_refcount (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] page_addr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_addr,
    output logic [1:0]  status,
    output logic        page_released,
    output logic [7:0]  count_after,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);
    import pfa_pkg::*;

    logic [PN_W-1:0] base_reg, base_next;
    logic [PN_W-1:0] end_reg, end_next;

    logic    clearing;
    logic    q_push;
    logic    q_pop;
    item_t   push_item;
    item_t   pop_item;
    q_stat_t q_stat;
    status_t status_enc;

    always_comb
    begin
        base_next = base_reg;
        end_next  = end_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASE: base_next = cfg_data;
                CFG_END:  end_next  = cfg_data;
                default:  base_next = base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            end_reg  <= END_RESET;
        end
        else
        begin
            base_reg <= base_next;
            end_reg  <= end_next;
        end
    end

    pfa_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .page_addr (page_addr),
        .base_page (base_reg),
        .end_page  (end_reg),
        .clearing  (clearing),
        .q_stat    (q_stat),
        .push      (q_push),
        .item      (push_item)
    );

    pfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    pfa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .base_page     (base_reg),
        .q_stat        (q_stat),
        .pop_item      (pop_item),
        .pop           (q_pop),
        .clearing      (clearing),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_addr      (out_addr),
        .status        (status_enc),
        .page_released (page_released),
        .count_after   (count_after)
    );

    assign status = status_enc;

    `PFA_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, clearing && in_valid, in_stall, "item accepted during clear")
    `PFA_ASSERT_NEXT(a_pop_spacing, clk, rst_n, q_pop, !q_pop, "back popped two items in a row")
    `PFA_ASSERT_IMP(a_release_ok, clk, rst_n, out_valid && page_released, status_enc == ST_OK, "release with error status")
    `PFA_ASSERT_IMP(a_alloc_count, clk, rst_n, out_valid && (out_addr != '0), (count_after == 8'd1) && (status_enc == ST_OK), "alloc result inconsistent")

endmodule
